FILE: rtl/core/arpc_pkg.sv
`timescale 1ns / 1ps

package arpc_pkg;

  // Address widths fixed by Ethernet and IPv4.
  localparam int unsigned MAC_W   = 48;
  localparam int unsigned IP_W    = 32;
  localparam int unsigned ENTRY_W = IP_W + MAC_W;

  localparam int unsigned CACHE_ENTRIES_DEF = 16;

  // Configuration port.
  localparam int unsigned CFG_W     = MAC_W;
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_OWN_MAC = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_OWN_IP  = 1'b1;

  localparam logic [15:0] PROTO_IPV4   = 16'h0800;
  localparam logic [15:0] ARP_OP_REQ   = 16'd1;
  localparam logic [7:0]  BCAST_OCTET  = 8'd255;
  localparam logic [MAC_W-1:0] MAC_BCAST = {6{BCAST_OCTET}};

  // Result kinds.
  localparam logic [2:0] KIND_UNSUP   = 3'd0;
  localparam logic [2:0] KIND_LEARN   = 3'd1;
  localparam logic [2:0] KIND_REPLY   = 3'd2;
  localparam logic [2:0] KIND_HIT     = 3'd3;
  localparam logic [2:0] KIND_REQUEST = 3'd4;

  // Opcodes of emitted frames.
  localparam logic [1:0] OP_NONE  = 2'd0;
  localparam logic [1:0] OP_REQ   = 2'd1;
  localparam logic [1:0] OP_REPLY = 2'd2;

  localparam logic CMD_PACKET = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  typedef struct packed {
    logic             command;
    logic [15:0]      proto_type;
    logic [15:0]      arp_opcode;
    logic [MAC_W-1:0] sender_mac;
    logic [IP_W-1:0]  sender_ip;
    logic [IP_W-1:0]  target_ip;
    logic [IP_W-1:0]  query_ip;
  } in_item_t;

  typedef struct packed {
    logic [2:0]       result_kind;
    logic [1:0]       frame_opcode;
    logic [MAC_W-1:0] frame_dest_mac;
    logic [MAC_W-1:0] frame_target_mac;
    logic [IP_W-1:0]  frame_target_ip;
    logic [MAC_W-1:0] found_mac;
    logic             table_full;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic update;
  } dp_cmd_t;

  typedef struct packed {
    logic scan_end;
  } dp_sts_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE,
    ST_OUT
  } state_e;

endpackage

FILE: rtl/core/arpc_stream_if.sv
`timescale 1ns / 1ps

interface arpc_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/core/arpc_ram.sv
`timescale 1ns / 1ps

module arpc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/arpc_ctrl.sv
`timescale 1ns / 1ps

module arpc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  arpc_pkg::dp_sts_t sts_i,
  output arpc_pkg::dp_cmd_t cmd_o
);
  import arpc_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_end) begin
          state_d = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        cmd_o.update = 1'b1;
        state_d      = ST_OUT;
      end
      ST_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/core/arpc_dp.sv
`timescale 1ns / 1ps

module arpc_dp #(
  parameter int unsigned CACHE_ENTRIES = arpc_pkg::CACHE_ENTRIES_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [arpc_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [arpc_pkg::CFG_W-1:0]     cfg_wdata_i,
  input  arpc_pkg::in_item_t             item_i,
  input  arpc_pkg::dp_cmd_t              cmd_i,
  output arpc_pkg::dp_sts_t              sts_o,
  output arpc_pkg::out_item_t            result_o
);
  import arpc_pkg::*;

  localparam int unsigned IDX_W = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CACHE_ENTRIES - 1);

  logic [MAC_W-1:0] own_mac_q;
  logic [IP_W-1:0]  own_ip_q;

  in_item_t         item_q;
  logic [IP_W-1:0]  key;

  logic             valid_q [CACHE_ENTRIES];
  logic             iss_q;
  logic [IDX_W-1:0] rd_idx_q;
  logic             cmp_vld_q;
  logic [IDX_W-1:0] cmp_idx_q;
  logic             hit_q;
  logic [IDX_W-1:0] slot_q;
  logic [MAC_W-1:0] mac_q;
  logic             free_found_q;
  logic [IDX_W-1:0] free_idx_q;

  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic               ram_re;
  logic [ENTRY_W-1:0] ram_rdata;
  logic [IP_W-1:0]    rd_ip;
  logic [MAC_W-1:0]   rd_mac;

  logic      match;
  logic      pkt_ok;
  logic      to_us;
  logic      set_valid;
  out_item_t res_d, res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_mac_q <= '0;
      own_ip_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_OWN_MAC: own_mac_q <= cfg_wdata_i;
        REG_OWN_IP:  own_ip_q  <= cfg_wdata_i[IP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q <= item_i;
    end
  end

  assign key = (item_q.command == CMD_LOOKUP) ? item_q.query_ip : item_q.sender_ip;

  // Read addresses are issued one a cycle; the compare runs in the cycle after each
  // read address because the table read is registered.
  assign ram_re = cmd_i.scan && iss_q;
  assign rd_ip  = ram_rdata[ENTRY_W-1 -: IP_W];
  assign rd_mac = ram_rdata[MAC_W-1:0];
  assign match  = cmp_vld_q && valid_q[cmp_idx_q] && (rd_ip == key);

  assign sts_o.scan_end = match || (cmp_vld_q && (cmp_idx_q == LAST_IDX));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iss_q        <= 1'b0;
      rd_idx_q     <= '0;
      cmp_vld_q    <= 1'b0;
      cmp_idx_q    <= '0;
      hit_q        <= 1'b0;
      free_found_q <= 1'b0;
    end else if (cmd_i.load) begin
      iss_q        <= 1'b1;
      rd_idx_q     <= '0;
      cmp_vld_q    <= 1'b0;
      hit_q        <= 1'b0;
      free_found_q <= 1'b0;
    end else begin
      cmp_vld_q <= ram_re;
      cmp_idx_q <= rd_idx_q;
      if (ram_re) begin
        if (rd_idx_q == LAST_IDX) begin
          iss_q <= 1'b0;
        end else begin
          rd_idx_q <= rd_idx_q + 1'b1;
        end
      end
      if (cmd_i.scan && match) begin
        hit_q <= 1'b1;
      end
      if (cmd_i.scan && cmp_vld_q && !valid_q[cmp_idx_q] && !free_found_q) begin
        free_found_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan && match) begin
      slot_q <= cmp_idx_q;
      mac_q  <= rd_mac;
    end
    if (cmd_i.scan && cmp_vld_q && !valid_q[cmp_idx_q] && !free_found_q) begin
      free_idx_q <= cmp_idx_q;
    end
  end

  assign pkt_ok    = (item_q.command == CMD_PACKET) && (item_q.proto_type == PROTO_IPV4);
  assign to_us     = (item_q.target_ip == own_ip_q);
  assign set_valid = cmd_i.update && pkt_ok && !hit_q && to_us && free_found_q;
  assign ram_we    = (cmd_i.update && pkt_ok && hit_q) || set_valid;
  assign ram_waddr = hit_q ? slot_q : free_idx_q;
  assign ram_wdata = {item_q.sender_ip, item_q.sender_mac};

  for (genvar g = 0; g < CACHE_ENTRIES; g++) begin : g_valid
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[g] <= 1'b0;
      end else if (set_valid && (free_idx_q == IDX_W'(g))) begin
        valid_q[g] <= 1'b1;
      end
    end
  end

  arpc_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (CACHE_ENTRIES)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (rd_idx_q),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    res_d = '0;
    if (item_q.command == CMD_LOOKUP) begin
      if (hit_q) begin
        res_d.result_kind = KIND_HIT;
        res_d.found_mac   = mac_q;
      end else begin
        res_d.result_kind     = KIND_REQUEST;
        res_d.frame_opcode    = OP_REQ;
        res_d.frame_dest_mac  = MAC_BCAST;
        res_d.frame_target_ip = item_q.query_ip;
      end
    end else if (!pkt_ok) begin
      res_d.result_kind = KIND_UNSUP;
    end else if (!to_us) begin
      res_d.result_kind = KIND_LEARN;
    end else begin
      res_d.table_full = !hit_q && !free_found_q;
      if (item_q.arp_opcode == ARP_OP_REQ) begin
        res_d.result_kind      = KIND_REPLY;
        res_d.frame_opcode     = OP_REPLY;
        res_d.frame_dest_mac   = item_q.sender_mac;
        res_d.frame_target_mac = item_q.sender_mac;
        res_d.frame_target_ip  = item_q.sender_ip;
      end else begin
        res_d.result_kind = KIND_LEARN;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.update) begin
      res_q <= res_d;
    end
  end

  assign result_o = res_q;

endmodule

FILE: rtl/core/arp_responder_cache.sv
`timescale 1ns / 1ps
// A result is valid once the cache scan has ended and the table update is done; the scan
// ends early when the address is found in the cache.
// One item at a time: a new item is not taken until the last result has been taken, and
// the cache RAM is scanned one entry a cycle for each item.
// Reset is asynchronous and active low; it clears all valid bits and both address
// registers at once, so no clearing pass is needed.

module arp_responder_cache #(
  parameter int unsigned CACHE_ENTRIES = arpc_pkg::CACHE_ENTRIES_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [arpc_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [arpc_pkg::CFG_W-1:0]     cfg_wdata_i,
  arpc_stream_if.sink                    item_i,
  arpc_stream_if.source                  result_o
);
  import arpc_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  arpc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (item_i.valid),
    .in_ready_o  (item_i.ready),
    .out_valid_o (result_o.valid),
    .out_ready_i (result_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  arpc_dp #(
    .CACHE_ENTRIES (CACHE_ENTRIES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .item_i      (item_i.data),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .result_o    (result_o.data)
  );

`ifndef SYNTHESIS
  // A new item is never taken while a result still waits for its transfer.
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(item_i.ready && result_o.valid))
    else $error("input ready while a result is pending");

  a_kind_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid |-> (result_o.data.result_kind <= KIND_REQUEST))
    else $error("result kind out of range");

  a_no_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_o.valid && (result_o.data.result_kind == KIND_UNSUP ||
                        result_o.data.result_kind == KIND_LEARN ||
                        result_o.data.result_kind == KIND_HIT))
    |-> (result_o.data.frame_opcode == OP_NONE))
    else $error("frame opcode set for a result that sends nothing");

  a_full_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_o.valid && result_o.data.table_full)
    |-> (result_o.data.result_kind == KIND_LEARN ||
         result_o.data.result_kind == KIND_REPLY))
    else $error("table full flagged on a result without an insert");
`endif

endmodule

FILE: tb/tb_arp_responder_cache.sv
`timescale 1ns / 1ps

module tb_arp_responder_cache;
  import arpc_pkg::*;

  localparam int unsigned CACHE_ENTRIES  = CACHE_ENTRIES_DEF;
  localparam int unsigned IP_POOL_SIZE   = 20;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned MAX_IDLE       = 14;
  localparam logic [15:0] OPC_REPLY      = 16'd2;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0]     cfg_wdata;

  arpc_stream_if #(.T(in_item_t))  item_if ();
  arpc_stream_if #(.T(out_item_t)) res_if ();

  arp_responder_cache #(
    .CACHE_ENTRIES(CACHE_ENTRIES)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata),
    .item_i     (item_if.sink),
    .result_o   (res_if.source)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow of the address cache and of our own identity.
  logic             bind_valid [CACHE_ENTRIES];
  logic [IP_W-1:0]  bind_ip    [CACHE_ENTRIES];
  logic [MAC_W-1:0] bind_mac   [CACHE_ENTRIES];
  logic [MAC_W-1:0] my_mac;
  logic [IP_W-1:0]  my_ip;

  logic [IP_W-1:0] ip_pool [IP_POOL_SIZE];
  out_item_t       pending_answers [$];

  bit idle_en = 1'b1;
  int mismatch_count  = 0;
  int results_checked = 0;
  int items_sent      = 0;
  int lookups_sent    = 0;
  int dropped_inserts = 0;
  int kind_count [5];
  int quiet_cycles    = 0;

  function automatic int find_binding(input logic [IP_W-1:0] ip);
    for (int k = 0; k < CACHE_ENTRIES; k++) begin
      if (bind_valid[k] && bind_ip[k] == ip) return k;
    end
    return -1;
  endfunction

  function automatic int free_slot();
    for (int k = 0; k < CACHE_ENTRIES; k++) begin
      if (!bind_valid[k]) return k;
    end
    return -1;
  endfunction

  // Works out the answer to one item and updates the shadow cache.
  function automatic out_item_t resolve_arp(input in_item_t it);
    out_item_t r;
    int        slot;
    r = '0;
    if (it.command == CMD_LOOKUP) begin
      slot = find_binding(it.query_ip);
      if (slot >= 0) begin
        r.result_kind = KIND_HIT;
        r.found_mac   = bind_mac[slot];
      end else begin
        r.result_kind     = KIND_REQUEST;
        r.frame_opcode    = OP_REQ;
        r.frame_dest_mac  = MAC_BCAST;
        r.frame_target_ip = it.query_ip;
      end
      return r;
    end
    if (it.proto_type != PROTO_IPV4) begin
      r.result_kind = KIND_UNSUP;
      return r;
    end
    slot = find_binding(it.sender_ip);
    if (slot >= 0) bind_mac[slot] = it.sender_mac;
    if (it.target_ip != my_ip) begin
      r.result_kind = KIND_LEARN;
      return r;
    end
    if (slot < 0) begin
      slot = free_slot();
      if (slot >= 0) begin
        bind_valid[slot] = 1'b1;
        bind_ip[slot]    = it.sender_ip;
        bind_mac[slot]   = it.sender_mac;
      end else begin
        r.table_full = 1'b1;
      end
    end
    if (it.arp_opcode != ARP_OP_REQ) begin
      r.result_kind = KIND_LEARN;
      return r;
    end
    r.result_kind      = KIND_REPLY;
    r.frame_opcode     = OP_REPLY;
    r.frame_dest_mac   = it.sender_mac;
    r.frame_target_mac = it.sender_mac;
    r.frame_target_ip  = it.sender_ip;
    return r;
  endfunction

  function automatic in_item_t make_item(input logic cmd, input logic [15:0] proto,
                                         input logic [15:0] opc, input logic [MAC_W-1:0] smac,
                                         input logic [IP_W-1:0] sip, input logic [IP_W-1:0] tip,
                                         input logic [IP_W-1:0] qip);
    in_item_t it;
    it.command    = cmd;
    it.proto_type = proto;
    it.arp_opcode = opc;
    it.sender_mac = smac;
    it.sender_ip  = sip;
    it.target_ip  = tip;
    it.query_ip   = qip;
    return it;
  endfunction

  function automatic logic [IP_W-1:0] pick_ip();
    if ($urandom_range(0, 7) == 0) return $urandom;
    return ip_pool[$urandom_range(0, IP_POOL_SIZE - 1)];
  endfunction

  // Mostly well-formed IPv4 traffic drawn from a small address pool, so that
  // refreshes, hits and a filling cache all occur; the rest is noise.
  function automatic in_item_t random_item();
    in_item_t it;
    int       pick;
    it.command = ($urandom_range(0, 3) == 0) ? CMD_LOOKUP : CMD_PACKET;
    pick = $urandom_range(0, 9);
    it.proto_type = (pick < 8) ? PROTO_IPV4 : 16'($urandom);
    pick = $urandom_range(0, 9);
    it.arp_opcode = (pick < 5) ? ARP_OP_REQ : (pick < 8) ? OPC_REPLY : 16'($urandom);
    it.sender_mac = {16'($urandom), 32'($urandom)};
    it.sender_ip  = pick_ip();
    it.target_ip  = ($urandom_range(0, 1) == 0) ? my_ip : pick_ip();
    it.query_ip   = pick_ip();
    return it;
  endfunction

  task automatic flag_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 40) $display("MISMATCH at %0t: %s", $realtime, msg);
  endtask

  task automatic compare_field(input string fname, input logic [63:0] got,
                               input logic [63:0] want);
    if (got !== want) begin
      flag_mismatch($sformatf("result %0d, %s: got %h, expected %h",
                              results_checked, fname, got, want));
    end
  endtask

  task automatic check_result(input out_item_t got);
    out_item_t want;
    if (pending_answers.size() == 0) begin
      flag_mismatch($sformatf("result of kind %0d with nothing outstanding",
                              got.result_kind));
      return;
    end
    want = pending_answers.pop_front();
    compare_field("result_kind", 64'(got.result_kind), 64'(want.result_kind));
    compare_field("frame_opcode", 64'(got.frame_opcode), 64'(want.frame_opcode));
    compare_field("frame_dest_mac", 64'(got.frame_dest_mac), 64'(want.frame_dest_mac));
    compare_field("frame_target_mac", 64'(got.frame_target_mac),
                  64'(want.frame_target_mac));
    compare_field("frame_target_ip", 64'(got.frame_target_ip), 64'(want.frame_target_ip));
    compare_field("found_mac", 64'(got.found_mac), 64'(want.found_mac));
    compare_field("table_full", 64'(got.table_full), 64'(want.table_full));
    if (want.result_kind <= KIND_REQUEST) kind_count[want.result_kind]++;
    if (want.table_full) dropped_inserts++;
    results_checked++;
  endtask

  // Valid is only lowered when a gap follows, so a back-to-back transfer
  // never sees two assignments to it in one step.
  task automatic send_item(input in_item_t it);
    int gap;
    gap = idle_en ? $urandom_range(0, MAX_IDLE) : 0;
    if (gap > 0) begin
      item_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    item_if.valid <= 1'b1;
    item_if.data  <= it;
    do begin
      @(posedge clk_i);
    end while (!item_if.ready);
    pending_answers.push_back(resolve_arp(it));
    items_sent++;
    if (it.command == CMD_LOOKUP) lookups_sent++;
  endtask

  task automatic drain();
    item_if.valid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_identity(input logic [MAC_W-1:0] mac, input logic [IP_W-1:0] ip);
    drain();
    cfg_we    <= 1'b1;
    cfg_idx   <= REG_OWN_MAC;
    cfg_wdata <= mac;
    @(posedge clk_i);
    cfg_idx   <= REG_OWN_IP;
    cfg_wdata <= CFG_W'(ip);
    @(posedge clk_i);
    cfg_we <= 1'b0;
    my_mac = mac;
    my_ip  = ip;
  endtask

  task automatic test_lookup_miss();
    send_item(make_item(CMD_LOOKUP, 16'hFFFF, 16'hFFFF, '1, '1, '1, 32'h0000_0000));
    send_item(make_item(CMD_LOOKUP, 16'h0000, 16'h0000, '0, '0, '0, 32'hFFFF_FFFF));
  endtask

  task automatic test_unsupported_proto();
    send_item(make_item(CMD_PACKET, 16'hFFFF, ARP_OP_REQ, '1, '0, my_ip, '1));
    send_item(make_item(CMD_PACKET, 16'h0000, ARP_OP_REQ, '1, '0, my_ip, '0));
  endtask

  task automatic test_learn_and_reply();
    send_item(make_item(CMD_PACKET, PROTO_IPV4, ARP_OP_REQ, '1, 32'h0, my_ip, '0));
    send_item(make_item(CMD_LOOKUP, PROTO_IPV4, ARP_OP_REQ, '0, '0, '0, 32'h0));
  endtask

  // The sender is already cached, so a packet aimed elsewhere still refreshes it.
  task automatic test_refresh();
    send_item(make_item(CMD_PACKET, PROTO_IPV4, OPC_REPLY, '0, 32'h0, 32'h0, '1));
    send_item(make_item(CMD_LOOKUP, 16'h1234, 16'h0, '1, '1, '1, 32'h0));
  endtask

  task automatic test_other_opcodes();
    send_item(make_item(CMD_PACKET, PROTO_IPV4, OPC_REPLY, 48'h0123_4567_89AB,
                        32'hFFFF_FFFF, my_ip, '0));
    send_item(make_item(CMD_PACKET, PROTO_IPV4, 16'hFFFF, 48'hA5A5_5A5A_0F0F,
                        32'h1234_5678, my_ip, '0));
    send_item(make_item(CMD_PACKET, PROTO_IPV4, 16'h0000, 48'hFEDC_BA98_7654,
                        32'hFFFF_FFFF, my_ip, '0));
    send_item(make_item(CMD_LOOKUP, PROTO_IPV4, '0, '0, '0, '0, 32'hFFFF_FFFF));
    send_item(make_item(CMD_PACKET, PROTO_IPV4, ARP_OP_REQ, 48'h1111_2222_3333,
                        32'h0A0B_0C0D, 32'h0A0B_0C0E, '0));
    send_item(make_item(CMD_LOOKUP, PROTO_IPV4, '0, '0, '0, '0, 32'h0A0B_0C0D));
  endtask

  task automatic test_random_traffic(input int count);
    for (int n = 0; n < count; n++) begin
      if (n % 100 == 0) idle_en = ($urandom_range(0, 3) != 0);
      send_item(random_item());
    end
    idle_en = 1'b1;
  endtask

  // Fill every free slot with fresh senders, then show that further inserts
  // are dropped while a request is still answered.
  task automatic test_table_full();
    for (int k = 0; k < 4 * CACHE_ENTRIES && free_slot() >= 0; k++) begin
      send_item(make_item(CMD_PACKET, PROTO_IPV4, OPC_REPLY, {16'($urandom), 32'($urandom)},
                          32'hA000_0000 + k, my_ip, '0));
    end
    send_item(make_item(CMD_PACKET, PROTO_IPV4, ARP_OP_REQ, 48'h0000_0000_0001,
                        32'hB000_0001, my_ip, '0));
    send_item(make_item(CMD_PACKET, PROTO_IPV4, OPC_REPLY, 48'h8000_0000_0000,
                        32'hB000_0002, my_ip, '0));
    send_item(make_item(CMD_LOOKUP, PROTO_IPV4, '0, '0, '0, '0, 32'hB000_0001));
  endtask

  task automatic test_random_after_full();
    for (int phase = 0; phase < 4; phase++) begin
      set_identity({16'($urandom), 32'($urandom)},
                   (phase == 0) ? ip_pool[1] : 32'($urandom));
      test_random_traffic(200);
    end
  endtask

  // Result side: a fresh stall is drawn for every result while idle gaps are enabled.
  initial begin
    int stall;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      stall = idle_en ? $urandom_range(0, MAX_IDLE) : 0;
      if (stall > 0) begin
        res_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      res_if.ready <= 1'b1;
      do begin
        @(posedge clk_i);
      end while (!(res_if.valid && res_if.ready));
      check_result(res_if.data);
    end
  end

  always @(posedge clk_i) begin
    if ((item_if.valid && item_if.ready) || (res_if.valid && res_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog: no transfer for %0d cycles, %0d results outstanding.",
               quiet_cycles, pending_answers.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    rst_ni        <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_idx       <= REG_OWN_MAC;
    cfg_wdata     <= '0;
    item_if.valid <= 1'b0;
    item_if.data  <= '0;
    res_if.ready  <= 1'b0;
    for (int k = 0; k < CACHE_ENTRIES; k++) begin
      bind_valid[k] = 1'b0;
      bind_ip[k]    = '0;
      bind_mac[k]   = '0;
    end
    for (int k = 0; k < 5; k++) kind_count[k] = 0;
    ip_pool[0] = 32'h0000_0000;
    ip_pool[1] = 32'hFFFF_FFFF;
    for (int k = 2; k < IP_POOL_SIZE; k++) ip_pool[k] = $urandom;
    my_mac = '0;
    my_ip  = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    set_identity('1, 32'hFFFF_FFFF);
    test_lookup_miss();
    test_unsupported_proto();
    test_learn_and_reply();
    test_refresh();
    test_other_opcodes();

    set_identity({16'($urandom), 32'($urandom)}, 32'($urandom));
    test_random_traffic(800);

    set_identity('0, 32'h0000_0000);
    test_table_full();

    test_random_after_full();

    drain();
    repeat (2 * (CACHE_ENTRIES + 3)) @(posedge clk_i);
    $display("Covered %0d items (%0d lookups) over seven identity settings; %0d results checked.",
             items_sent, lookups_sent, results_checked);
    $display("Replies %0d, requests %0d, hits %0d, learned %0d, unsupported %0d, dropped %0d.",
             kind_count[KIND_REPLY], kind_count[KIND_REQUEST], kind_count[KIND_HIT],
             kind_count[KIND_LEARN], kind_count[KIND_UNSUP], dropped_inserts);
    if (mismatch_count == 0 && pending_answers.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/arpc_pkg.sv
rtl/core/arpc_stream_if.sv
rtl/core/arpc_ram.sv
rtl/core/arpc_ctrl.sv
rtl/core/arpc_dp.sv
rtl/core/arp_responder_cache.sv
tb/tb_arp_responder_cache.sv
